// ----- rtl/lcx_pkg.sv -----
// Shared types, widths and helper functions for the line/circle intersection block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lcx_pkg;

	localparam int COORD_W = 32;          // coordinate width, raw fixed point
	localparam int RAD_W   = COORD_W - 1; // radius width, unsigned
	localparam int OP_W    = COORD_W + 1; // difference of two coordinates
	localparam int MAG_W   = 136;         // wide magnitude path, even for the root unit
	localparam int Q_DEPTH = 4;           // work queue between front and back
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [1:0] ST_MISS  = 2'd0;
	localparam logic [1:0] ST_TAN   = 2'd1;
	localparam logic [1:0] ST_SEC   = 2'd2;
	localparam logic [1:0] ST_DEGEN = 2'd3;

	// classified query, line in the form A*x + B*y = C, sign and magnitude
	typedef struct packed {
		logic                       degen;
		logic                       a_neg;
		logic [OP_W-1:0]            a_mag;
		logic                       b_neg;
		logic [OP_W-1:0]            b_mag;
		logic                       fx_neg;
		logic [OP_W-1:0]            fx_mag;
		logic                       fy_neg;
		logic [OP_W-1:0]            fy_mag;
		logic signed [COORD_W-1:0]  cx;
		logic signed [COORD_W-1:0]  cy;
		logic [RAD_W-1:0]           r;
	} work_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} sm_t;

	function automatic sm_t sm_add(input logic an, input logic [MAG_W-1:0] am,
			input logic bn, input logic [MAG_W-1:0] bm);
		sm_t res;
		if (an == bn) begin
			res.neg = an;
			res.mag = am + bm;
		end else if (am >= bm) begin
			res.neg = an;
			res.mag = am - bm;
		end else begin
			res.neg = bn;
			res.mag = bm - am;
		end
		return res;
	endfunction

	// signed quotient plus centre, clamped to the coordinate range
	function automatic logic [COORD_W-1:0] coord_sat(input logic neg,
			input logic [MAG_W-1:0] mag, input logic [COORD_W-1:0] c);
		logic signed [MAG_W+1:0] v;
		logic signed [MAG_W+1:0] cmax;
		logic signed [MAG_W+1:0] cmin;
		cmax = {{(MAG_W+3-COORD_W){1'b0}}, {(COORD_W-1){1'b1}}};
		cmin = {{(MAG_W+3-COORD_W){1'b1}}, {(COORD_W-1){1'b0}}};
		v = {2'b00, mag};
		if (neg) begin
			v = -v;
		end
		v = v + {{(MAG_W+2-COORD_W){c[COORD_W-1]}}, c};
		if (v > cmax) begin
			return cmax[COORD_W-1:0];
		end else if (v < cmin) begin
			return cmin[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/line_circle_intersection_top.sv -----
// Line / circle intersection, top level: front end, work queue and back end.
// Depends on lcx_pkg, lcx_front, lcx_fifo and lcx_back.
//
// Usage:
//   Input channel: drive the seven query fields and raise push; a transaction
//   completes on a clock edge with push high and full low. Queries are
//   classified on entry and held in a four-entry work queue, so up to four
//   queries are taken back to back while the back end is busy.
//   Result channel: while empty is low, the oldest result sits on point_x,
//   point_y, status and last; pop high with empty low takes it. A query gives
//   one result (degenerate line, miss, tangent) or two secant points, last
//   marking the final one.
//   Arithmetic: the back end runs a serial shift-add multiplier (one multiplier
//   bit per cycle, stopping early on short operands), a one-bit-per-cycle
//   root unit and a restoring divider, used once per coordinate. A degenerate
//   line skips all arithmetic; for a secant pair most of the time goes in
//   the 136-bit divider.
//   Stall: while a result waits unpopped the back end holds before the next
//   result; the queue keeps taking queries until full.
//   Reset: arst_n low empties the queue and drops any pending result.
`default_nettype none

module line_circle_intersection_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic signed [lcx_pkg::COORD_W-1:0] line_ax,
	input  wire logic signed [lcx_pkg::COORD_W-1:0] line_ay,
	input  wire logic signed [lcx_pkg::COORD_W-1:0] line_bx,
	input  wire logic signed [lcx_pkg::COORD_W-1:0] line_by,
	input  wire logic signed [lcx_pkg::COORD_W-1:0] centre_x,
	input  wire logic signed [lcx_pkg::COORD_W-1:0] centre_y,
	input  wire logic [lcx_pkg::RAD_W-1:0]     radius,
	output logic                               empty,
	input  wire logic                          pop,
	output logic signed [lcx_pkg::COORD_W-1:0] point_x,
	output logic signed [lcx_pkg::COORD_W-1:0] point_y,
	output logic [1:0]                         status,
	output logic                               last
);
	import lcx_pkg::*;

	work_t              work, q_data;
	logic               q_empty, q_pop;
	logic [COORD_W-1:0] px, py;

	lcx_front u_front (
		.line_ax  (line_ax),
		.line_ay  (line_ay),
		.line_bx  (line_bx),
		.line_by  (line_by),
		.centre_x (centre_x),
		.centre_y (centre_y),
		.radius   (radius),
		.work     (work)
	);

	lcx_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (work),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	lcx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.point_x (px),
		.point_y (py),
		.status  (status),
		.last    (last)
	);

	assign point_x = $signed(px);
	assign point_y = $signed(py);

endmodule

`default_nettype wire

// ----- rtl/lcx_front.sv -----
// Front end: takes one query and classifies it into line coefficients and offsets.
// Depends on lcx_pkg.
`default_nettype none

module lcx_front (
	input  wire logic [lcx_pkg::COORD_W-1:0] line_ax,
	input  wire logic [lcx_pkg::COORD_W-1:0] line_ay,
	input  wire logic [lcx_pkg::COORD_W-1:0] line_bx,
	input  wire logic [lcx_pkg::COORD_W-1:0] line_by,
	input  wire logic [lcx_pkg::COORD_W-1:0] centre_x,
	input  wire logic [lcx_pkg::COORD_W-1:0] centre_y,
	input  wire logic [lcx_pkg::RAD_W-1:0]   radius,
	output lcx_pkg::work_t                   work
);
	import lcx_pkg::*;

	logic [OP_W-1:0] dx, dy, fx, fy;
	logic [OP_W-1:0] dx_mag, dy_mag, fx_mag, fy_mag;
	logic            dx_nz;

	always_comb begin
		dx = {line_bx[COORD_W-1], line_bx} - {line_ax[COORD_W-1], line_ax};
		dy = {line_by[COORD_W-1], line_by} - {line_ay[COORD_W-1], line_ay};
		fx = {line_ax[COORD_W-1], line_ax} - {centre_x[COORD_W-1], centre_x};
		fy = {line_ay[COORD_W-1], line_ay} - {centre_y[COORD_W-1], centre_y};
		dx_mag = dx[OP_W-1] ? (~dx + 1'b1) : dx;
		dy_mag = dy[OP_W-1] ? (~dy + 1'b1) : dy;
		fx_mag = fx[OP_W-1] ? (~fx + 1'b1) : fx;
		fy_mag = fy[OP_W-1] ? (~fy + 1'b1) : fy;
		dx_nz  = (dx != '0);

		work.degen  = !dx_nz && (dy == '0);
		// scaled slope form: A = dy*sign(dx), B = -|dx|; vertical line: A = 1, B = 0
		work.a_neg  = dx_nz ? (dx[OP_W-1] ^ dy[OP_W-1]) : 1'b0;
		work.a_mag  = dx_nz ? dy_mag : OP_W'(1);
		work.b_neg  = dx_nz;
		work.b_mag  = dx_mag;
		work.fx_neg = fx[OP_W-1];
		work.fx_mag = fx_mag;
		work.fy_neg = fy[OP_W-1];
		work.fy_mag = fy_mag;
		work.cx     = centre_x;
		work.cy     = centre_y;
		work.r      = radius;
	end

endmodule

`default_nettype wire

// ----- rtl/lcx_fifo.sv -----
// Short work queue between the classifying front end and the arithmetic back end.
// Depends on lcx_pkg.
`default_nettype none

module lcx_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  lcx_pkg::work_t      wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output lcx_pkg::work_t      rd_data,
	output logic                empty
);
	import lcx_pkg::*;

	work_t            mem_q [Q_DEPTH];
	work_t            rd_data_q;
	logic [Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	// the popped entry shows up on rd_data the cycle after the pop
	assign rd_data = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
		if (do_rd) begin
			rd_data_q <= mem_q[rd_ptr_q];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lcx_mul.sv -----
// Shift-add multiplier over wide magnitudes, one multiplier bit per cycle.
// Stops as soon as the remaining multiplier bits are zero. Depends on lcx_pkg.
`default_nettype none

module lcx_mul (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [lcx_pkg::MAG_W-1:0] a,
	input  wire logic [lcx_pkg::MAG_W-1:0] b,
	output logic                           done,
	output logic [lcx_pkg::MAG_W-1:0]      p
);
	import lcx_pkg::*;

	logic             busy_q;
	logic [MAG_W-1:0] a_q, b_q, acc_q;

	assign done = busy_q && (b_q == '0);
	assign p    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lcx_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating.
// Depends on lcx_pkg.
`default_nettype none

module lcx_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [lcx_pkg::MAG_W-1:0] n,
	input  wire logic [lcx_pkg::MAG_W-1:0] d,
	output logic                           done,
	output logic [lcx_pkg::MAG_W-1:0]      q
);
	import lcx_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rem_q, quo_q, d_q;
	logic [MAG_W:0]   r2, diff;
	logic             ge;

	assign done = busy_q && (cnt_q == '0);
	assign q    = quo_q;
	assign r2   = {rem_q, quo_q[MAG_W-1]};
	assign diff = r2 - {1'b0, d_q};
	assign ge   = (r2 >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= n;
			d_q   <= d;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lcx_sqrt.sv -----
// Floor square root, one result bit per cycle (two radicand bits per step).
// Depends on lcx_pkg.
`default_nettype none

module lcx_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [lcx_pkg::MAG_W-1:0] n,
	output logic                           done,
	output logic [lcx_pkg::MAG_W-1:0]      root
);
	import lcx_pkg::*;

	logic             busy_q;
	logic [MAG_W-1:0] x_q, res_q, one_q, t;

	assign done = busy_q && (one_q == '0);
	assign root = res_q;
	assign t    = res_q + one_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= n;
			res_q <= '0;
			one_q <= {2'b01, {(MAG_W-2){1'b0}}};
		end else if (busy_q && (one_q != '0)) begin
			if (x_q >= t) begin
				x_q   <= x_q - t;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lcx_back.sv -----
// Back end: sequences the serial multiplier, root and divider over one queued query
// and holds each result transaction until popped. Depends on lcx_pkg, lcx_mul,
// lcx_div and lcx_sqrt.
`default_nettype none

module lcx_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  lcx_pkg::work_t              q_data,
	input  wire logic                   q_empty,
	output logic                        q_pop,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [lcx_pkg::COORD_W-1:0] point_x,
	output logic [lcx_pkg::COORD_W-1:0] point_y,
	output logic [1:0]                  status,
	output logic                        last
);
	import lcx_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_AFX  = 5'd1;
	localparam logic [4:0] S_BFY  = 5'd2;
	localparam logic [4:0] S_AA   = 5'd3;
	localparam logic [4:0] S_BB   = 5'd4;
	localparam logic [4:0] S_RR   = 5'd5;
	localparam logic [4:0] S_LHS  = 5'd6;
	localparam logic [4:0] S_RHS  = 5'd7;
	localparam logic [4:0] S_NX   = 5'd8;
	localparam logic [4:0] S_NY   = 5'd9;
	localparam logic [4:0] S_SQRT = 5'd10;
	localparam logic [4:0] S_AS   = 5'd11;
	localparam logic [4:0] S_BS   = 5'd12;
	localparam logic [4:0] S_DX   = 5'd13;
	localparam logic [4:0] S_DY   = 5'd14;
	localparam logic [4:0] S_EMIT = 5'd15;
	localparam logic [4:0] S_LOAD = 5'd16;

	logic [4:0]         st_q;
	logic               issued_q, res_v_q;
	work_t              item_q;
	logic               t1n_q, cs_neg_q, tan_q, k_q;
	logic [MAG_W-1:0]   t1_q, cs_q, den_q, lhs_q, nx_q, ny_q, s_q, as_q, bs_q;
	logic [COORD_W-1:0] px_q, py_q, res_x_q, res_y_q;
	logic [1:0]         pst_q, res_st_q;
	logic               plast_q, res_last_q;

	logic             is_mul, mul_start, div_start, sqrt_start, start_any, unit_done;
	logic             mul_done, div_done, sqrt_done, emit_fire, rhs_lt;
	logic [MAG_W-1:0] ma, mb, mul_p, div_q, root, div_n, disc;
	logic             nxn, nyn;
	sm_t              cs_sum, num_x, num_y;

	always_comb begin
		ma = '0;
		mb = '0;
		is_mul = 1'b1;
		case (st_q)
			S_AFX: begin ma = MAG_W'(item_q.a_mag); mb = MAG_W'(item_q.fx_mag); end
			S_BFY: begin ma = MAG_W'(item_q.b_mag); mb = MAG_W'(item_q.fy_mag); end
			S_AA:  begin ma = MAG_W'(item_q.a_mag); mb = MAG_W'(item_q.a_mag); end
			S_BB:  begin ma = MAG_W'(item_q.b_mag); mb = MAG_W'(item_q.b_mag); end
			S_RR:  begin ma = MAG_W'(item_q.r);     mb = MAG_W'(item_q.r);     end
			S_LHS: begin ma = den_q;                mb = t1_q;                 end
			S_RHS: begin ma = cs_q;                 mb = cs_q;                 end
			S_NX:  begin ma = cs_q;                 mb = MAG_W'(item_q.a_mag); end
			S_NY:  begin ma = cs_q;                 mb = MAG_W'(item_q.b_mag); end
			S_AS:  begin ma = s_q;                  mb = MAG_W'(item_q.a_mag); end
			S_BS:  begin ma = s_q;                  mb = MAG_W'(item_q.b_mag); end
			default: is_mul = 1'b0;
		endcase
	end

	assign mul_start  = !issued_q && is_mul;
	assign div_start  = !issued_q && ((st_q == S_DX) || (st_q == S_DY));
	assign sqrt_start = !issued_q && (st_q == S_SQRT);
	assign start_any  = mul_start || div_start || sqrt_start;
	assign unit_done  = mul_done || div_done || sqrt_done;
	assign emit_fire  = (st_q == S_EMIT) && (!res_v_q || pop);
	assign q_pop      = (st_q == S_IDLE) && !q_empty;

	assign rhs_lt = (lhs_q < mul_p);
	assign disc   = lhs_q - mul_p;
	assign nxn    = item_q.a_neg ^ cs_neg_q;
	assign nyn    = item_q.b_neg ^ cs_neg_q;
	assign cs_sum = sm_add(t1n_q, t1_q, item_q.b_neg ^ item_q.fy_neg, mul_p);
	// first point: (nx + Bs, ny - As); second point: (nx - Bs, ny + As)
	assign num_x  = sm_add(nxn, nx_q, item_q.b_neg ^ k_q, bs_q);
	assign num_y  = sm_add(nyn, ny_q, item_q.a_neg ^ !k_q, as_q);
	assign div_n  = (st_q == S_DY) ? num_y.mag : num_x.mag;

	lcx_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (ma),
		.b      (mb),
		.done   (mul_done),
		.p      (mul_p)
	);

	lcx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (den_q),
		.done   (div_done),
		.q      (div_q)
	);

	lcx_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (lhs_q),
		.done   (sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			issued_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (start_any) begin
				issued_q <= 1'b1;
			end else if (unit_done) begin
				issued_q <= 1'b0;
			end
			if (emit_fire) begin
				res_v_q <= 1'b1;
			end else if (pop) begin
				res_v_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: if (!q_empty) st_q <= S_LOAD;
				S_LOAD: st_q <= q_data.degen ? S_EMIT : S_AFX;
				S_AFX:  if (mul_done) st_q <= S_BFY;
				S_BFY:  if (mul_done) st_q <= S_AA;
				S_AA:   if (mul_done) st_q <= S_BB;
				S_BB:   if (mul_done) st_q <= S_RR;
				S_RR:   if (mul_done) st_q <= S_LHS;
				S_LHS:  if (mul_done) st_q <= S_RHS;
				S_RHS:  if (mul_done) st_q <= rhs_lt ? S_EMIT : S_NX;
				S_NX:   if (mul_done) st_q <= S_NY;
				S_NY:   if (mul_done) st_q <= tan_q ? S_DX : S_SQRT;
				S_SQRT: if (sqrt_done) st_q <= S_AS;
				S_AS:   if (mul_done) st_q <= S_BS;
				S_BS:   if (mul_done) st_q <= S_DX;
				S_DX:   if (div_done) st_q <= S_DY;
				S_DY:   if (div_done) st_q <= S_EMIT;
				S_EMIT: if (emit_fire) st_q <= plast_q ? S_IDLE : S_DX;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (!q_empty) begin
				k_q     <= 1'b0;
				px_q    <= '0;
				py_q    <= '0;
				pst_q   <= ST_DEGEN;
				plast_q <= 1'b1;
			end
			S_LOAD: item_q <= q_data;
			S_AFX: if (mul_done) begin
				t1_q  <= mul_p;
				t1n_q <= item_q.a_neg ^ item_q.fx_neg;
			end
			S_BFY: if (mul_done) begin
				cs_neg_q <= cs_sum.neg;
				cs_q     <= cs_sum.mag;
			end
			S_AA:  if (mul_done) den_q <= mul_p;
			S_BB:  if (mul_done) den_q <= den_q + mul_p;
			S_RR:  if (mul_done) t1_q <= mul_p;
			S_LHS: if (mul_done) lhs_q <= mul_p;
			S_RHS: if (mul_done) begin
				lhs_q <= disc;
				tan_q <= (disc == '0);
				pst_q <= ST_MISS;
			end
			S_NX: if (mul_done) nx_q <= mul_p;
			S_NY: if (mul_done) begin
				ny_q <= mul_p;
				// tangent: foot point only, no offset along the line
				as_q  <= '0;
				bs_q  <= '0;
				pst_q <= ST_TAN;
			end
			S_SQRT: if (sqrt_done) s_q <= root;
			S_AS:   if (mul_done) as_q <= mul_p;
			S_BS: if (mul_done) begin
				bs_q    <= mul_p;
				pst_q   <= ST_SEC;
				plast_q <= 1'b0;
			end
			S_DX: if (div_done) px_q <= coord_sat(num_x.neg, div_q, item_q.cx);
			S_DY: if (div_done) py_q <= coord_sat(num_y.neg, div_q, item_q.cy);
			S_EMIT: if (emit_fire) begin
				res_x_q    <= px_q;
				res_y_q    <= py_q;
				res_st_q   <= pst_q;
				res_last_q <= plast_q;
				k_q        <= 1'b1;
				plast_q    <= 1'b1;
			end
			default: ;
		endcase
	end

	assign empty   = !res_v_q;
	assign point_x = res_x_q;
	assign point_y = res_y_q;
	assign status  = res_st_q;
	assign last    = res_last_q;

endmodule

`default_nettype wire

// ----- tb/line_circle_intersection_top_tb.sv -----
// Self-checking testbench for line_circle_intersection_top: directed table, then random queries.
// Depends on lcx_pkg and the line_circle_intersection_top RTL.
`default_nettype none

module line_circle_intersection_top_tb;
	import lcx_pkg::*;

	localparam int LIMIT = 3000000;
	localparam int N_RAND = 440;

	typedef logic signed [199:0] wide_t;

	typedef struct {
		logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
		logic [RAD_W-1:0]          r;
		int                        st; // status known by inspection, -1 if not
	} query_t;

	typedef struct {
		logic signed [COORD_W-1:0] x, y;
		logic [1:0]                st;
		logic                      lst;
	} point_t;

	logic clk, arst_n, push, full, empty, pop, last;
	logic signed [COORD_W-1:0] line_ax, line_ay, line_bx, line_by, centre_x, centre_y;
	logic signed [COORD_W-1:0] point_x, point_y;
	logic [RAD_W-1:0] radius;
	logic [1:0] status;

	point_t expected_points[$];
	int errors = 0;
	int cycles = 0;
	int mode = 0; // 0 none, 1 sender idle, 2 receiver stall, 3 both
	int row_st = -1;

	line_circle_intersection_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.line_ax(line_ax), .line_ay(line_ay), .line_bx(line_bx), .line_by(line_by),
		.centre_x(centre_x), .centre_y(centre_y), .radius(radius),
		.empty(empty), .pop(pop), .point_x(point_x), .point_y(point_y),
		.status(status), .last(last)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("line_circle_intersection_top_tb: FAIL");
			$finish;
		end
	end

	function automatic wide_t isqrt(input wide_t n);
		wide_t x, res, b;
		x = n;
		res = 0;
		b = wide_t'(1) << 196;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input wide_t num, input wide_t den,
			input logic signed [COORD_W-1:0] c);
		wide_t v;
		v = num / den + wide_t'(c);
		if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
		if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
		return v[COORD_W-1:0];
	endfunction

	// append one expected result transaction
	function automatic void add_point(input point_t p);
		expected_points.insert(expected_points.size(), p);
	endfunction

	// work out the points for one query and queue them
	function automatic int predict_query(input query_t q);
		wide_t dx, dy, a, b, fx, fy, cs, den, lhs, rhs, s, nx, ny;
		point_t p;
		dx = wide_t'(q.bx) - wide_t'(q.ax);
		dy = wide_t'(q.by) - wide_t'(q.ay);
		if (dx == 0 && dy == 0) begin
			p = '{0, 0, ST_DEGEN, 1'b1};
			add_point(p);
			return int'(ST_DEGEN);
		end
		if (dx != 0) begin
			a = dx > 0 ? dy : -dy;
			b = dx > 0 ? -dx : dx;
		end else begin
			a = 1;
			b = 0;
		end
		fx = wide_t'(q.ax) - wide_t'(q.cx);
		fy = wide_t'(q.ay) - wide_t'(q.cy);
		cs = a * fx + b * fy;
		den = a * a + b * b;
		lhs = wide_t'({1'b0, q.r}) * wide_t'({1'b0, q.r}) * den;
		rhs = cs * cs;
		if (lhs < rhs) begin
			p = '{0, 0, ST_MISS, 1'b1};
			add_point(p);
			return int'(ST_MISS);
		end
		nx = a * cs;
		ny = b * cs;
		if (lhs == rhs) begin
			p = '{clamp_coord(nx, den, q.cx), clamp_coord(ny, den, q.cy), ST_TAN, 1'b1};
			add_point(p);
			return int'(ST_TAN);
		end
		s = isqrt(lhs - rhs);
		p = '{clamp_coord(nx + b * s, den, q.cx), clamp_coord(ny - a * s, den, q.cy),
			ST_SEC, 1'b0};
		add_point(p);
		p = '{clamp_coord(nx - b * s, den, q.cx), clamp_coord(ny + a * s, den, q.cy),
			ST_SEC, 1'b1};
		add_point(p);
		return int'(ST_SEC);
	endfunction

	// accept side: predict on every input transaction
	always @(posedge clk) begin
		query_t q;
		int st;
		if (arst_n && push && !full) begin
			q = '{line_ax, line_ay, line_bx, line_by, centre_x, centre_y, radius, -1};
			st = predict_query(q);
			if (row_st >= 0 && st != row_st) begin
				$display("%0t: table status expected %0d actual %0d", $time, row_st, st);
				errors++;
			end
		end
	end

	// result side: compare each popped transaction with the oldest expectation
	always @(posedge clk) begin
		point_t e;
		if (arst_n && pop && !empty) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h status=%0d last=%b",
					$time, point_x, point_y, status, last);
				errors++;
			end else begin
				e = expected_points.pop_front();
				if (point_x !== e.x) begin
					$display("%0t: point_x expected %h actual %h", $time, e.x, point_x);
					errors++;
				end
				if (point_y !== e.y) begin
					$display("%0t: point_y expected %h actual %h", $time, e.y, point_y);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
				if (last !== e.lst) begin
					$display("%0t: last expected %b actual %b", $time, e.lst, last);
					errors++;
				end
			end
		end
	end

	initial begin
		pop = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop = !((mode == 2 && $urandom_range(99) < 67) ||
				(mode == 3 && $urandom_range(99) < 16));
		end
	end

	task automatic send_query(input query_t q);
		logic took;
		while ((mode == 1 && $urandom_range(99) < 67) ||
				(mode == 3 && $urandom_range(99) < 16)) begin
			push = 0;
			@(negedge clk);
		end
		line_ax = q.ax; line_ay = q.ay; line_bx = q.bx; line_by = q.by;
		centre_x = q.cx; centre_y = q.cy; radius = q.r;
		row_st = q.st;
		push = 1;
		do begin
			@(posedge clk);
			took = !full;
			@(negedge clk);
		end while (!took);
		push = 0;
	endtask

	function automatic logic signed [COORD_W-1:0] near(input int bits);
		return $signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
	endfunction

	localparam logic signed [COORD_W-1:0] MAXC = 32'sh7fffffff;
	localparam logic signed [COORD_W-1:0] MINC = 32'sh80000000;
	localparam logic [RAD_W-1:0] MAXR = '1;

	query_t dir_rows[18] = '{
		'{0, 0, 0, 0, 0, 0, RAD_W'(0), int'(ST_DEGEN)},
		'{MAXC, MINC, MAXC, MINC, MINC, MAXC, MAXR, int'(ST_DEGEN)},
		'{-5, 10, 5, 10, 0, 0, RAD_W'(10), int'(ST_TAN)},       // horizontal tangent
		'{10, -3, 10, 7, 0, 0, RAD_W'(10), int'(ST_TAN)},       // vertical tangent
		'{5, 0, 5, 9, 0, 0, RAD_W'(0), int'(ST_MISS)},
		'{0, -4, 0, 4, 0, 0, RAD_W'(0), int'(ST_TAN)},          // zero radius through the centre
		'{-7, 20, 7, 20, 0, 0, RAD_W'(3), int'(ST_MISS)},
		'{-100, 0, 100, 0, 0, 0, RAD_W'(50), int'(ST_SEC)},
		'{100, 0, -100, 0, 0, 0, RAD_W'(50), int'(ST_SEC)},     // points swapped
		'{0, -100, 0, 100, 0, 0, RAD_W'(50), int'(ST_SEC)},
		'{3, 1, -2, 4, 1, -1, RAD_W'(65536), -1},
		'{MINC, MINC, MAXC, MAXC, 0, 0, MAXR, int'(ST_SEC)},
		'{MINC, MAXC, MAXC, MINC, MAXC, MAXC, MAXR, -1},
		'{MAXC, 0, MINC, 0, MAXC, MAXC, MAXR, -1},   // horizontal tangent at the edge of the range
		'{0, MINC, 0, MAXC, MINC, MINC, MAXR, -1},
		'{MINC, MINC, MINC, MAXC, MAXC, MAXC, RAD_W'(0), int'(ST_MISS)},
		'{MAXC, 1, MINC, -1, 0, 0, RAD_W'(1), -1},
		'{1, 1, 2, 3, 0, 0, RAD_W'(0), -1}
	};

	initial begin
		query_t q;
		int pick;
		arst_n = 0;
		push = 0;
		line_ax = 0; line_ay = 0; line_bx = 0; line_by = 0;
		centre_x = 0; centre_y = 0; radius = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (dir_rows[i]) send_query(dir_rows[i]);
		for (int i = 0; i < N_RAND; i++) begin
			mode = i / (N_RAND / 4);
			pick = $urandom_range(9);
			if (pick < 3) begin
				q = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					RAD_W'($urandom), -1};
			end else begin
				// local geometry so that the circle is usually hit
				q.cx = near(21);
				q.cy = near(21);
				q.ax = q.cx + near(20);
				q.ay = q.cy + near(20);
				q.bx = pick == 8 ? q.ax : q.cx + near(20);
				q.by = q.cy + near(20);
				q.r = RAD_W'($urandom_range(1 << 20));
				q.st = -1;
				if (pick == 9) begin
					q.bx = q.ax;
					q.by = q.ay;
				end
			end
			send_query(q);
		end
		row_st = -1;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (1500) @(posedge clk);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("line_circle_intersection_top_tb: PASS");
		end else begin
			$display("line_circle_intersection_top_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
